// ----- rtl/vspc_pkg.sv -----
// Shared types and constants of the voxel span column parser.
`timescale 1ns / 1ps
`default_nettype none
package vspc_pkg;

    localparam int CFG_IDX_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE_LOG2  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE_LOG2  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_HEIGHT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIPE_LIGHT   = 8'd3;

    // byte roles
    localparam logic [2:0] ROLE_COUNT = 3'd0;
    localparam logic [2:0] ROLE_START = 3'd1;
    localparam logic [2:0] ROLE_END   = 3'd2;
    localparam logic [2:0] ROLE_AIR   = 3'd3;
    localparam logic [2:0] ROLE_BLUE  = 3'd4;

    // sticky fault codes
    localparam logic [1:0] FAULT_NONE       = 2'd0;
    localparam logic [1:0] FAULT_HEADER     = 2'd1;
    localparam logic [1:0] FAULT_COLOUR     = 2'd2;
    localparam logic [1:0] FAULT_AFTER_END  = 2'd3;

    // positions inside a 4-byte word
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_LAST   = 2'd3;

    localparam logic [8:0] MIN_AUTO_HEIGHT = 9'd64;
    localparam logic [7:0] WIPED_LIGHT     = 8'd1;

    localparam int COLUMNS_W = 24;

    typedef struct packed {
        logic [3:0] x_size_log2;
        logic [3:0] z_size_log2;
        logic [7:0] fixed_height;
        logic       wipe_light;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_role;
        logic       column_done;
        logic [7:0] column_words;
        logic       map_done;
        logic [8:0] map_height;
        logic [1:0] fault;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/vspc_cfg_regs.sv -----
// Configuration register file of the voxel span column parser.
`timescale 1ns / 1ps
`default_nettype none
module vspc_cfg_regs (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [vspc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire  [7:0]                      cfg_wdata,
    output vspc_pkg::cfg_t                  cfg
);
    import vspc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                REG_X_SIZE_LOG2:  cfg_next.x_size_log2  = cfg_wdata[3:0];
                REG_Z_SIZE_LOG2:  cfg_next.z_size_log2  = cfg_wdata[3:0];
                REG_FIXED_HEIGHT: cfg_next.fixed_height = cfg_wdata;
                REG_WIPE_LIGHT:   cfg_next.wipe_light   = cfg_wdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_size_log2  <= 4'd9;
            cfg_reg.z_size_log2  <= 4'd9;
            cfg_reg.fixed_height <= 8'd0;
            cfg_reg.wipe_light   <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vspc_span_decoder.sv -----
// Span header and colour word decoder with column and map tracking state.
`timescale 1ns / 1ps
`default_nettype none
module vspc_span_decoder #(
    parameter int COLUMN_BUFFER_WORDS = 257,
    parameter int MAX_SIDE_LOG2       = 12
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 advance,
    input  wire  [7:0]          data_byte,
    input  vspc_pkg::cfg_t      cfg,
    output vspc_pkg::result_t   result
);
    import vspc_pkg::*;

    localparam int WU_W   = $clog2(COLUMN_BUFFER_WORDS);
    localparam int TOT_W  = 2 * MAX_SIDE_LOG2 + 1;
    localparam int CMP_W  = (TOT_W > COLUMNS_W) ? TOT_W : COLUMNS_W;

    logic [1:0]           quad_reg,      quad_next;
    logic                 in_colours_reg, in_colours_next;
    logic [7:0]           span_count_reg, span_count_next;
    logic [7:0]           span_start_reg, span_start_next;
    logic [7:0]           colours_left_reg, colours_left_next;
    logic [WU_W-1:0]      words_used_reg, words_used_next;
    logic [COLUMNS_W-1:0] columns_reg,   columns_next;
    logic [7:0]           highest_reg,   highest_next;
    logic [1:0]           fault_reg,     fault_next;
    logic                 finished_reg,  finished_next;

    logic                 full;
    logic                 end_col;
    logic [WU_W-1:0]      words_inc;
    logic [7:0]           colours_dec;
    logic [3:0]           x_log2, z_log2;
    logic [4:0]           side_sum;
    logic [CMP_W-1:0]     total;
    logic [COLUMNS_W-1:0] columns_inc;
    logic [8:0]           auto_height;

    assign full = (({1'b0, words_used_reg} + (WU_W+1)'(1))
                   >= (WU_W+1)'(COLUMN_BUFFER_WORDS));
    assign words_inc   = words_used_reg + WU_W'(1);
    assign colours_dec = colours_left_reg - 8'd1;
    assign x_log2 = (cfg.x_size_log2 > 4'(MAX_SIDE_LOG2)) ? 4'(MAX_SIDE_LOG2)
                                                          : cfg.x_size_log2;
    assign z_log2 = (cfg.z_size_log2 > 4'(MAX_SIDE_LOG2)) ? 4'(MAX_SIDE_LOG2)
                                                          : cfg.z_size_log2;
    assign side_sum    = {1'b0, x_log2} + {1'b0, z_log2};
    assign total       = CMP_W'(1) << side_sum;
    assign columns_inc = columns_reg + COLUMNS_W'(1);
    assign auto_height = {1'b0, highest_reg} + 9'd1;

    always_comb begin
        quad_next         = quad_reg;
        in_colours_next   = in_colours_reg;
        span_count_next   = span_count_reg;
        span_start_next   = span_start_reg;
        colours_left_next = colours_left_reg;
        words_used_next   = words_used_reg;
        columns_next      = columns_reg;
        highest_next      = highest_reg;
        fault_next        = fault_reg;
        finished_next     = finished_reg;
        end_col           = 1'b0;
        result            = '0;
        result.out_byte   = data_byte;
        result.byte_role  = ROLE_COUNT;

        if (fault_reg != FAULT_NONE) begin
            // hold the fault, drop the byte
        end else if (finished_reg) begin
            fault_next = FAULT_AFTER_END;
        end else if (!in_colours_reg) begin
            result.byte_role = {1'b0, quad_reg};
            if (quad_reg == QUAD_FIRST && full) begin
                fault_next = FAULT_HEADER;
            end else begin
                case (quad_reg)
                    QUAD_FIRST:  span_count_next = data_byte;
                    QUAD_SECOND: span_start_next = data_byte;
                    QUAD_THIRD: begin
                        if (data_byte > highest_reg) highest_next = data_byte;
                        colours_left_next = (span_count_reg == 8'd0)
                            ? (data_byte - span_start_reg + 8'd1)
                            : (span_count_reg - 8'd1);
                    end
                    default: begin
                        words_used_next = words_inc;
                        if (colours_left_reg != 8'd0) in_colours_next = 1'b1;
                        else if (span_count_reg == 8'd0) end_col = 1'b1;
                    end
                endcase
                quad_next = quad_reg + 2'd1;
            end
        end else begin
            result.byte_role = ROLE_BLUE + {1'b0, quad_reg};
            if (quad_reg == QUAD_FIRST && full) begin
                fault_next = FAULT_COLOUR;
            end else begin
                if (quad_reg == QUAD_LAST) begin
                    if (cfg.wipe_light) result.out_byte = WIPED_LIGHT;
                    words_used_next   = words_inc;
                    colours_left_next = colours_dec;
                    if (colours_dec == 8'd0) begin
                        in_colours_next = 1'b0;
                        if (span_count_reg == 8'd0) end_col = 1'b1;
                    end
                end
                quad_next = quad_reg + 2'd1;
            end
        end

        if (end_col) begin
            result.column_done  = 1'b1;
            result.column_words = 8'(words_used_next - WU_W'(2));
            words_used_next     = WU_W'(1);
            columns_next        = columns_inc;
            if (CMP_W'(columns_inc) >= total) begin
                result.map_done = 1'b1;
                finished_next   = 1'b1;
                if (cfg.fixed_height != 8'd0) begin
                    result.map_height = {1'b0, cfg.fixed_height};
                end else begin
                    result.map_height = (auto_height < MIN_AUTO_HEIGHT)
                        ? MIN_AUTO_HEIGHT : auto_height;
                end
            end
        end

        result.fault = fault_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_reg         <= QUAD_FIRST;
            in_colours_reg   <= 1'b0;
            span_count_reg   <= 8'd0;
            span_start_reg   <= 8'd0;
            colours_left_reg <= 8'd0;
            words_used_reg   <= WU_W'(1);
            columns_reg      <= '0;
            highest_reg      <= 8'd0;
            fault_reg        <= FAULT_NONE;
            finished_reg     <= 1'b0;
        end else if (advance) begin
            quad_reg         <= quad_next;
            in_colours_reg   <= in_colours_next;
            span_count_reg   <= span_count_next;
            span_start_reg   <= span_start_next;
            colours_left_reg <= colours_left_next;
            words_used_reg   <= words_used_next;
            columns_reg      <= columns_next;
            highest_reg      <= highest_next;
            fault_reg        <= fault_next;
            finished_reg     <= finished_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/voxel_span_column_parser.sv -----
// Top level of the voxel span column parser: input register, decoder, output register.
// Path: a byte accepted on s_ is held in the input register, then in the result register,
//   before it is presented on m_; a low m_tready holds it in the result register.
// Throughput: one byte per cycle unless m_tready stalls it; one decoder state update per byte.
// Reset: aresetn low clears the pipeline valid flags, the decoder state and the
//   configuration registers to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module voxel_span_column_parser #(
    parameter int COLUMN_BUFFER_WORDS = 257,
    parameter int MAX_SIDE_LOG2       = 12
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input byte stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] data_byte
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // [7:0] out_byte, [15:8] column_words,
                                    // [24:16] map_height, [31:25] zero
    output logic        m_tlast,    // column_done
    output logic [7:0]  m_tuser,    // [2:0] byte_role, [3] map_done, [5:4] fault,
                                    // [7:6] zero
    // configuration write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [vspc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire  [7:0]  cfg_wdata
);
    import vspc_pkg::*;

    cfg_t       cfg;
    result_t    result;
    result_t    out_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;

    // Advance a byte from the input register into the result register whenever
    // the result register is empty or is being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // Accept a new transaction when the input register is empty or moving on.
    assign s_tready = !in_valid_reg || advance;

    vspc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vspc_span_decoder #(
        .COLUMN_BUFFER_WORDS (COLUMN_BUFFER_WORDS),
        .MAX_SIDE_LOG2       (MAX_SIDE_LOG2)
    ) u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // Input register: hold the byte until the decoder takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Result register: load on advance, drop once the sink takes the transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.map_height, out_reg.column_words, out_reg.out_byte};
    assign m_tlast  = out_reg.column_done;
    assign m_tuser  = {2'd0, out_reg.fault, out_reg.map_done, out_reg.byte_role};

endmodule
`default_nettype wire

// ----- tb/sv/column_decode_scoreboard_pkg.sv -----
// Scoreboard of the voxel span column parser: a byte-level decoder model and its result queue.
`timescale 1ns / 1ps
package column_decode_scoreboard_pkg;
    import vspc_pkg::*;

    localparam int         BUFFER_WORDS  = 257;
    localparam int         SIDE_LOG2_MAX = 12;
    localparam logic [1:0] QUAD_SECOND   = 2'd1;

    class column_decode_scoreboard;
        // configuration copy
        logic [3:0]  x_log2;
        logic [3:0]  z_log2;
        logic [7:0]  fixed_height;
        logic        wipe_light;
        // decoder state
        logic [1:0]  quad;
        logic        in_colours;
        logic [7:0]  span_count;
        logic [7:0]  span_start;
        logic [7:0]  colours_left;
        logic [8:0]  words_used;
        logic [23:0] columns_seen;
        logic [7:0]  highest_end;
        logic [1:0]  sticky_fault;
        logic        finished;

        result_t     expected_echoes[$];
        int          echoes_checked;
        int          mismatches;

        function new();
            x_log2         = 4'd9;
            z_log2         = 4'd9;
            fixed_height   = 8'd0;
            wipe_light     = 1'b1;
            quad           = QUAD_FIRST;
            in_colours     = 1'b0;
            span_count     = 8'd0;
            span_start     = 8'd0;
            colours_left   = 8'd0;
            words_used     = 9'd1;
            columns_seen   = 24'd0;
            highest_end    = 8'd0;
            sticky_fault   = FAULT_NONE;
            finished       = 1'b0;
            echoes_checked = 0;
            mismatches     = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
            case (idx)
                REG_X_SIZE_LOG2:  x_log2       = value[3:0];
                REG_Z_SIZE_LOG2:  z_log2       = value[3:0];
                REG_FIXED_HEIGHT: fixed_height = value;
                REG_WIPE_LIGHT:   wipe_light   = value[0];
                default: ;
            endcase
        endfunction

        function logic [4:0] side_log2(logic [3:0] v);
            return (v > SIDE_LOG2_MAX) ? 5'(SIDE_LOG2_MAX) : {1'b0, v};
        endfunction

        function bit buffer_full();
            return int'(words_used) + 1 >= BUFFER_WORDS;
        endfunction

        function int pending();
            return expected_echoes.size();
        endfunction

        // Advance the decoder by one accepted byte and queue the echo it must produce.
        function void decode_byte(logic [7:0] b);
            result_t     r;
            logic        end_col;
            logic [24:0] total;
            r           = '0;
            r.out_byte  = b;
            r.byte_role = ROLE_COUNT;
            end_col     = 1'b0;
            if (sticky_fault != FAULT_NONE) begin
                // hold the fault, drop the byte
            end else if (finished) begin
                sticky_fault = FAULT_AFTER_END;
            end else if (!in_colours) begin
                r.byte_role = ROLE_COUNT + 3'(quad);
                if (quad == QUAD_FIRST && buffer_full()) begin
                    sticky_fault = FAULT_HEADER;
                end else begin
                    case (quad)
                        QUAD_FIRST:  span_count = b;
                        QUAD_SECOND: span_start = b;
                        QUAD_THIRD: begin
                            if (b > highest_end) highest_end = b;
                            colours_left = (span_count == 8'd0) ? 8'(b - span_start + 8'd1)
                                                                : 8'(span_count - 8'd1);
                        end
                        default: begin
                            words_used = words_used + 9'd1;
                            if (colours_left != 8'd0) in_colours = 1'b1;
                            else if (span_count == 8'd0) end_col = 1'b1;
                        end
                    endcase
                    quad = quad + 2'd1;
                end
            end else begin
                r.byte_role = ROLE_BLUE + 3'(quad);
                if (quad == QUAD_FIRST && buffer_full()) begin
                    sticky_fault = FAULT_COLOUR;
                end else begin
                    if (quad == QUAD_LAST) begin
                        if (wipe_light) r.out_byte = WIPED_LIGHT;
                        words_used   = words_used + 9'd1;
                        colours_left = colours_left - 8'd1;
                        if (colours_left == 8'd0) begin
                            in_colours = 1'b0;
                            if (span_count == 8'd0) end_col = 1'b1;
                        end
                    end
                    quad = quad + 2'd1;
                end
            end

            if (end_col) begin
                total          = 25'd1 << (side_log2(x_log2) + side_log2(z_log2));
                r.column_done  = 1'b1;
                r.column_words = 8'(words_used - 9'd2);
                words_used     = 9'd1;
                columns_seen   = columns_seen + 24'd1;
                if ({1'b0, columns_seen} >= total) begin
                    r.map_done = 1'b1;
                    finished   = 1'b1;
                    if (fixed_height != 8'd0) begin
                        r.map_height = {1'b0, fixed_height};
                    end else begin
                        r.map_height = {1'b0, highest_end} + 9'd1;
                        if (r.map_height < MIN_AUTO_HEIGHT) r.map_height = MIN_AUTO_HEIGHT;
                    end
                end
            end
            r.fault = sticky_fault;
            expected_echoes.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_field(string name, logic [8:0] want, logic [8:0] got);
            if (got !== want)
                report($sformatf("echo %0d %s: got %0h, expected %0h",
                                 echoes_checked, name, got, want));
        endtask

        task check_echo(result_t got);
            result_t want;
            if (expected_echoes.size() == 0) begin
                report($sformatf("echo %0d arrived with no byte pending: %h",
                                 echoes_checked, got));
                echoes_checked++;
                return;
            end
            want = expected_echoes.pop_front();
            check_field("out_byte",     want.out_byte,     got.out_byte);
            check_field("byte_role",    want.byte_role,    got.byte_role);
            check_field("column_done",  want.column_done,  got.column_done);
            check_field("column_words", want.column_words, got.column_words);
            check_field("map_done",     want.map_done,     got.map_done);
            check_field("map_height",   want.map_height,   got.map_height);
            check_field("fault",        want.fault,        got.fault);
            echoes_checked++;
        endtask
    endclass

endpackage

// ----- tb/sv/voxel_span_column_parser_test.sv -----
// Self-checking testbench of the voxel span column parser: column streams against a byte model.
`timescale 1ns / 1ps
module voxel_span_column_parser_test;
    import vspc_pkg::*;
    import column_decode_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 5;
    localparam int PHASE_BYTES      = 350;
    localparam int TRAILING_BYTES   = 12;
    localparam int DRAIN_CYCLES     = 8;
    localparam int FIRST_UNUSED_REG = int'(REG_WIPE_LIGHT) + 1;
    localparam int LAST_REG_INDEX   = (1 << CFG_IDX_W) - 1;

    // receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    // ways the map stream is brought to its end
    localparam int END_BY_MAP             = 0;
    localparam int END_BY_HEADER_OVERFLOW = 1;
    localparam int END_BY_COLOUR_OVERFLOW = 2;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'd0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tlast;
    logic [7:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [7:0]           cfg_wdata = 8'd0;

    column_decode_scoreboard board;
    result_t                 echo_seen;
    logic [7:0]              column_bytes[$];
    logic [7:0]              end_cap;
    int                      burst_left      = 0;
    int                      bytes_sent      = 0;
    int                      cycle_count     = 0;
    bit                      hold_off_request = 1'b0;
    bit                      hold_off_done    = 1'b0;

    voxel_span_column_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Give up on a hung run well past the slowest legal one.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("voxel_span_column_parser test failed");
            $finish;
        end
    end

    // Unpack every accepted result transaction and check it against the oldest expected echo.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            echo_seen              = '0;
            echo_seen.out_byte     = m_tdata[7:0];
            echo_seen.column_words = m_tdata[15:8];
            echo_seen.map_height   = m_tdata[24:16];
            echo_seen.column_done  = m_tlast;
            echo_seen.byte_role    = m_tuser[2:0];
            echo_seen.map_done     = m_tuser[3];
            echo_seen.fault        = m_tuser[5:4];
            board.check_echo(echo_seen);
        end
    end

    // Receiver: switch between stall patterns after runs of random length. Once asked, hold off
    // for a long stretch so the pipeline fills and back-pressures the byte stream.
    initial begin : rx_stall
        int stall_mode;
        int mode_left;
        int tick;
        stall_mode = RX_ALWAYS;
        mode_left  = 0;
        tick       = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_request && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            case (stall_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 99) < 60);
                default:   m_tready <= (tick % 4) != 0;
            endcase
        end
    end

    // Offer one byte and hold it until the input transaction completes. Bytes go out in
    // bursts of random length with random gaps in between.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.decode_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_column();
        while (column_bytes.size() != 0) send_byte(column_bytes.pop_front());
    endtask

    // Drop valid and wait until every byte has been echoed back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // Leave cfg_valid high; the caller lowers it after the last write of a group.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_register(idx, value);
    endtask

    function automatic void push_word(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3);
        column_bytes.push_back(b0);
        column_bytes.push_back(b1);
        column_bytes.push_back(b2);
        column_bytes.push_back(b3);
    endfunction

    function automatic void push_colours(input int n);
        for (int i = 0; i < n; i++)
            push_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // A span that is not the last one: count = colours + 1.
    function automatic void push_mid_span(input int n);
        push_word(8'(n + 1), 8'($urandom), 8'($urandom_range(0, end_cap)), 8'($urandom));
        push_colours(n);
    endfunction

    // The last span of a column: count 0, colours = end - start + 1 (start may wrap past end).
    function automatic void push_last_span(input int n);
        logic [7:0] span_end;
        span_end = 8'($urandom_range(0, end_cap));
        push_word(8'd0, 8'(int'(span_end) + 1 - n), span_end, 8'($urandom));
        push_colours(n);
    endfunction

    // Mostly short colour runs; even four long spans stay well inside the column buffer.
    function automatic int colour_run_length();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
    endfunction

    function automatic void make_random_column();
        int spans;
        if ($urandom_range(0, 59) == 0) begin
            // one deep last span, up to the fullest column that does not overflow
            push_last_span(($urandom_range(0, 3) == 0) ? 254 : $urandom_range(150, 253));
        end else begin
            spans = $urandom_range(1, 4);
            for (int i = 1; i < spans; i++) push_mid_span(colour_run_length());
            push_last_span(colour_run_length());
        end
    endfunction

    // Reconfigure while idle, then stream random columns. The column total is kept at
    // 4096 or more so that no phase ends the map.
    task automatic run_phase(input int phase);
        logic [3:0]  x_log2;
        logic [3:0]  z_log2;
        logic [7:0]  height;
        int          x_eff;
        int          target;
        case (phase)
            1: begin x_log2 = 4'd0;  z_log2 = 4'd12; height = 8'd0;   end
            2: begin x_log2 = 4'd12; z_log2 = 4'd0;  height = 8'd255; end
            3: begin x_log2 = 4'd15; z_log2 = 4'd15; height = 8'($urandom); end
            default: begin
                x_log2 = 4'($urandom);
                x_eff  = (x_log2 > SIDE_LOG2_MAX) ? SIDE_LOG2_MAX : int'(x_log2);
                z_log2 = 4'($urandom_range(SIDE_LOG2_MAX - x_eff, 15));
                height = 8'($urandom);
            end
        endcase
        wait_idle();
        // upper data bits carry noise that the narrow registers must drop
        write_register(REG_X_SIZE_LOG2, {4'($urandom), x_log2});
        write_register(REG_Z_SIZE_LOG2, {4'($urandom), z_log2});
        write_register(REG_FIXED_HEIGHT, height);
        write_register(REG_WIPE_LIGHT, {7'($urandom), 1'(phase % 2)});
        write_register(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_INDEX)),
                       8'($urandom));
        cfg_valid <= 1'b0;
        if (phase == 2) hold_off_request = 1'b1;
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) begin
            make_random_column();
            send_column();
        end
    endtask

    // Bring the stream to its one terminal event: map end, header overflow or colour
    // overflow. All three are sticky until reset, so each run picks one of them.
    task automatic finish_stream();
        int         n_log2;
        logic [3:0] x_log2;
        logic [3:0] z_log2;
        logic [7:0] height;
        case ($urandom_range(END_BY_MAP, END_BY_COLOUR_OVERFLOW))
            END_BY_MAP: begin
                case ($urandom_range(0, 2))
                    0:       height = 8'd0;
                    1:       height = 8'd255;
                    default: height = 8'($urandom_range(1, 254));
                endcase
                if ($urandom_range(0, 1) == 0) begin
                    // total of one column: the next column end overshoots it
                    x_log2 = 4'd0;
                    z_log2 = 4'd0;
                end else begin
                    // smallest power of two above the columns so far: reach it exactly
                    n_log2 = 0;
                    while ((1 << n_log2) <= board.columns_seen) n_log2++;
                    x_log2 = 4'(n_log2 / 2);
                    z_log2 = 4'(n_log2 - n_log2 / 2);
                end
                wait_idle();
                write_register(REG_FIXED_HEIGHT, height);
                write_register(REG_X_SIZE_LOG2, {4'($urandom), x_log2});
                write_register(REG_Z_SIZE_LOG2, {4'($urandom), z_log2});
                cfg_valid <= 1'b0;
                while (!board.finished) begin
                    make_random_column();
                    send_column();
                end
            end
            END_BY_HEADER_OVERFLOW: begin
                // 255 words stored; the next header's first byte finds the buffer full
                push_mid_span(254);
                column_bytes.push_back(8'($urandom));
            end
            default: begin
                // 254 words, one more header fits, its first colour word does not
                push_mid_span(253);
                push_mid_span(1);
            end
        endcase
        for (int i = 0; i < TRAILING_BYTES; i++) column_bytes.push_back(8'($urandom));
        send_column();
    endtask

    initial begin
        board = new();
        // Cap span ends in some runs so that the automatic height can fall to its minimum.
        end_cap = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(10, 120));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: largest map, wiped light bytes.
        write_register(REG_X_SIZE_LOG2, 8'd12);
        write_register(REG_Z_SIZE_LOG2, 8'd12);
        write_register(REG_FIXED_HEIGHT, 8'($urandom));
        write_register(REG_WIPE_LIGHT, 8'd1);
        cfg_valid <= 1'b0;

        // span with count 1 (no colours, column goes on)
        push_word(8'd1, 8'h00, end_cap, 8'hFF);
        // span with count 3: two colour words, light bytes replaced
        push_word(8'd3, 8'h05, 8'h00, 8'h07);
        push_word(8'h00, 8'hFF, 8'h55, 8'hAA);
        push_word(8'hFF, 8'h00, 8'hAA, 8'h55);
        // empty last span: end one below start, column ends on the air byte
        push_word(8'd0, 8'h01, 8'h00, 8'h20);
        // last span whose start wraps past its end: two colour words
        push_word(8'd0, 8'hFF, 8'h00, 8'h80);
        push_word(8'h12, 8'h34, 8'h56, 8'h00);
        push_word(8'hED, 8'hCB, 8'hA9, 8'hFF);
        send_column();

        for (int phase = 1; phase <= RANDOM_PHASES; phase++) run_phase(phase);
        finish_stream();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("voxel_span_column_parser test passed");
        end else begin
            $display("voxel_span_column_parser test failed");
        end
        $finish;
    end

endmodule
